[hdl/hunk_relocation_patcher_unit_macros.svh]
// Assertion macros shared by the relocation patcher RTL.
`ifndef HUNK_RELOCATION_PATCHER_UNIT_MACROS_SVH
`define HUNK_RELOCATION_PATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/hrp_pkg.sv]
`default_nettype none

package hrp_pkg;

	// Width of the exact, unwrapped fixup sum.
	localparam int ExactW = 34;
	localparam int OffW   = 24;

	typedef enum logic [3:0] {
		KIND_ABS32_N   = 4'd0,
		KIND_ABS16U_N  = 4'd1,
		KIND_REL32_N   = 4'd2,
		KIND_REL16_N   = 4'd3,
		KIND_ABS32_S   = 4'd4,
		KIND_ABS16_S   = 4'd5,
		KIND_PCREL16_S = 4'd6,
		KIND_HR16_N    = 4'd7,
		KIND_HR16_S    = 4'd8,
		KIND_HR32_N    = 4'd9,
		KIND_HR32_S    = 4'd10
	} kind_t;

	// How the final sum is written back into the field.
	typedef enum logic [1:0] {
		OUT_NAT32,
		OUT_SWP32,
		OUT_NAT16,
		OUT_SWP16
	} out_mode_t;

	// Which range check applies to the exact sum.
	typedef enum logic [1:0] {
		CHK_NONE,
		CHK_UNS16,
		CHK_SGN16
	} chk_t;

	typedef struct packed {
		out_mode_t mode;
		chk_t      chk;
	} ctl_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

`default_nettype wire

[hdl/hunk_relocation_patcher_unit.sv]
`default_nettype none

// Relocation fixup pipeline: each input transaction carries one relocation (kind in tuser,
// stored field, target address, hunk base and field offset in tdata) and yields exactly one
// output transaction with the patched field in its stored byte layout plus a range-error
// flag for the checked 16-bit kinds. The block accepts one transaction per clock unless the
// output stalls, and it has three register stages from input acceptance to output valid:
// operand decode and byte swap, the two partial sums, and the final subtraction with
// range check and write-back swap. The whole pipeline advances together; it freezes only
// while the output register holds a result that the consumer has not taken, so results stay
// in order and nothing is dropped or repeated. Unknown kinds pass the stored field through
// unchanged with no error.
module hunk_relocation_patcher_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// stored_value[31:0], target_address[63:32], hunk_base[95:64], field_offset[119:96]
	input  wire logic [119:0] s_axis_tdata,
	// func[3:0]
	input  wire logic [3:0]   s_axis_tuser,

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// patched_value[31:0], range_error[32], zero fill [39:33]
	output logic [39:0]       m_axis_tdata
);

	// Pipeline advance: every stage moves when the output register is free or being drained.
	logic ce;
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	// ---------------------------------------------------------------- stage 1 decode
	logic [31:0]                     in_sv;
	logic [31:0]                     in_tgt;
	logic [31:0]                     in_base;
	logic [hrp_pkg::OffW-1:0]        in_off;
	logic [15:0]                     in_lo;
	logic [15:0]                     in_lo_sw;
	logic signed [hrp_pkg::ExactW-1:0] a_d;
	logic                            use_tgt_d;
	logic                            use_base_d;
	logic                            use_off_d;
	hrp_pkg::ctl_t                   ctl_d;

	assign in_sv    = s_axis_tdata[31:0];
	assign in_tgt   = s_axis_tdata[63:32];
	assign in_base  = s_axis_tdata[95:64];
	assign in_off   = s_axis_tdata[119:96];
	assign in_lo    = in_sv[15:0];
	assign in_lo_sw = hrp_pkg::swap16(in_lo);

	always_comb begin
		a_d        = $signed({{(hrp_pkg::ExactW-32){1'b0}}, in_sv});
		use_tgt_d  = 1'b1;
		use_base_d = 1'b0;
		use_off_d  = 1'b0;
		ctl_d.mode = hrp_pkg::OUT_NAT32;
		ctl_d.chk  = hrp_pkg::CHK_NONE;
		unique case (s_axis_tuser)
			hrp_pkg::KIND_ABS32_N, hrp_pkg::KIND_HR32_N: begin
			end
			hrp_pkg::KIND_ABS16U_N: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){1'b0}}, in_lo});
				ctl_d.mode = hrp_pkg::OUT_NAT16;
				ctl_d.chk  = hrp_pkg::CHK_UNS16;
			end
			hrp_pkg::KIND_REL32_N: begin
				use_base_d = 1'b1;
			end
			hrp_pkg::KIND_REL16_N: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){in_lo[15]}}, in_lo});
				use_base_d = 1'b1;
				ctl_d.mode = hrp_pkg::OUT_NAT16;
				ctl_d.chk  = hrp_pkg::CHK_SGN16;
			end
			hrp_pkg::KIND_ABS32_S, hrp_pkg::KIND_HR32_S: begin
				a_d        = $signed({{(hrp_pkg::ExactW-32){1'b0}}, hrp_pkg::swap32(in_sv)});
				ctl_d.mode = hrp_pkg::OUT_SWP32;
			end
			hrp_pkg::KIND_ABS16_S: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){in_lo_sw[15]}}, in_lo_sw});
				ctl_d.mode = hrp_pkg::OUT_SWP16;
				ctl_d.chk  = hrp_pkg::CHK_SGN16;
			end
			hrp_pkg::KIND_PCREL16_S: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){in_lo_sw[15]}}, in_lo_sw});
				use_base_d = 1'b1;
				use_off_d  = 1'b1;
				ctl_d.mode = hrp_pkg::OUT_SWP16;
				ctl_d.chk  = hrp_pkg::CHK_SGN16;
			end
			hrp_pkg::KIND_HR16_N: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){1'b0}}, in_lo});
				ctl_d.mode = hrp_pkg::OUT_NAT16;
			end
			hrp_pkg::KIND_HR16_S: begin
				a_d        = $signed({{(hrp_pkg::ExactW-16){1'b0}}, in_lo_sw});
				ctl_d.mode = hrp_pkg::OUT_SWP16;
			end
			default: begin
				// Unknown kind: the field passes through untouched.
				use_tgt_d = 1'b0;
			end
		endcase
	end

	logic                              valid_s1;
	logic signed [hrp_pkg::ExactW-1:0] a_s1;
	logic signed [hrp_pkg::ExactW-1:0] tgt_s1;
	logic signed [hrp_pkg::ExactW-1:0] base_s1;
	logic [hrp_pkg::OffW-1:0]          off_s1;
	hrp_pkg::ctl_t                     ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s1    <= a_d;
			tgt_s1  <= use_tgt_d ?
				$signed({{(hrp_pkg::ExactW-32){in_tgt[31]}}, in_tgt}) : '0;
			base_s1 <= use_base_d ?
				$signed({{(hrp_pkg::ExactW-32){in_base[31]}}, in_base}) : '0;
			off_s1  <= use_off_d ? in_off : '0;
			ctl_s1  <= ctl_d;
		end
	end

	// ---------------------------------------------------------------- stage 2 partial sums
	logic                              valid_s2;
	logic signed [hrp_pkg::ExactW-1:0] sum_s2;
	logic signed [hrp_pkg::ExactW-1:0] sub_s2;
	hrp_pkg::ctl_t                     ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s2 <= a_s1 + tgt_s1;
			sub_s2 <= base_s1 +
				$signed({{(hrp_pkg::ExactW-hrp_pkg::OffW){1'b0}}, off_s1});
			ctl_s2 <= ctl_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3 check and write-back
	logic signed [hrp_pkg::ExactW-1:0] exact;
	logic [31:0]                       patched;
	logic                              err;
	logic                              sgn_fits;

	assign exact    = sum_s2 - sub_s2;
	// A signed 16-bit result fits when all bits from 15 upward agree.
	assign sgn_fits = (&exact[hrp_pkg::ExactW-1:15]) || !(|exact[hrp_pkg::ExactW-1:15]);

	always_comb begin
		unique case (ctl_s2.mode)
			hrp_pkg::OUT_NAT32: patched = exact[31:0];
			hrp_pkg::OUT_SWP32: patched = hrp_pkg::swap32(exact[31:0]);
			hrp_pkg::OUT_NAT16: patched = {16'h0000, exact[15:0]};
			hrp_pkg::OUT_SWP16: patched = {16'h0000, hrp_pkg::swap16(exact[15:0])};
			default:            patched = exact[31:0];
		endcase
		unique case (ctl_s2.chk)
			hrp_pkg::CHK_UNS16: err = exact[hrp_pkg::ExactW-1] || (|exact[hrp_pkg::ExactW-2:16]);
			hrp_pkg::CHK_SGN16: err = !sgn_fits;
			default:            err = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			m_axis_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata <= {7'd0, err, patched};
		end
	end

	// ---------------------------------------------------------------- assertions
	`include "hunk_relocation_patcher_unit_macros.svh"

	`HRP_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_s1, "accepted transaction did not enter stage 1")
	`HRP_ASSERT_NEXT(a_s2_reaches_out, valid_s2 && ce, m_axis_tvalid, "stage 2 result did not reach the output register")
	`HRP_ASSERT_NEXT(a_unchecked_no_err, valid_s2 && ce && ctl_s2.chk == hrp_pkg::CHK_NONE, !m_axis_tdata[32], "range error raised for an unchecked kind")

endmodule

`default_nettype wire
